@@ design/slhs_pkg.sv @@
// Shared types, constants and helper functions for the stray light hood
// suppression pipeline. No dependencies; every design file imports it.
package slhs_pkg;

  localparam int ROT_STEPS  = 16;   // CORDIC micro-rotations per angle
  localparam int SQRT_STEPS = 31;   // root bits of a 62-bit radicand
  localparam int DIV_STEPS  = 17;   // quotient bits 16 down to 0
  localparam int ROT_IDX_W  = $clog2(ROT_STEPS);
  localparam int DIV_IDX_W  = $clog2(DIV_STEPS);

  localparam int CW       = 34;     // CORDIC datapath width
  localparam int RAD_W    = 2 * SQRT_STEPS;
  localparam int REM_W    = SQRT_STEPS + 4;
  localparam int NUM_W    = 34;
  localparam int Q_W      = 17;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t CORDIC_GAIN = 34'sd652032875;

  localparam logic [Q_W-1:0] Q15_ONE     = 17'd32768;
  localparam logic [Q_W-1:0] ONE_DEG     = 17'd182;
  localparam logic [Q_W-1:0] CLOUD_ATTEN = 17'd22938;
  localparam logic [Q_W-1:0] TRANS_LOSS  = 17'd4915;
  localparam logic [Q_W-1:0] TRANS_FLOOR = 17'd22938;

  typedef enum logic [2:0] {
    REG_INNER     = 3'd0,
    REG_OUTER     = 3'd1,
    REG_SUPP_LO   = 3'd2,
    REG_SUPP_HI   = 3'd3,
    REG_FILTER_EN = 3'd4
  } reg_idx_t;

  // Word attributes that ride alongside the arithmetic cells.
  typedef struct packed {
    logic [15:0] cloud;
    logic [2:0]  flip;
    logic        neg;
    logic [30:0] ac;
    logic [15:0] sep;
  } sb_t;

  // atan(2^-i) with 2^32 per full turn.
  function automatic cw_t atan_step(input logic [ROT_IDX_W-1:0] i);
    cw_t r;
    case (i)
      4'd0:    r = 34'sd536870912;
      4'd1:    r = 34'sd316933406;
      4'd2:    r = 34'sd167458907;
      4'd3:    r = 34'sd85004756;
      4'd4:    r = 34'sd42667331;
      4'd5:    r = 34'sd21354465;
      4'd6:    r = 34'sd10679838;
      4'd7:    r = 34'sd5340245;
      4'd8:    r = 34'sd2670163;
      4'd9:    r = 34'sd1335087;
      4'd10:   r = 34'sd667544;
      4'd11:   r = 34'sd333772;
      4'd12:   r = 34'sd166886;
      4'd13:   r = 34'sd83443;
      4'd14:   r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

  // Q15 product, rounded half up.
  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                          input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = 34'(a) * 34'(b) + 34'd16384;
    return p[Q_W+14:15];
  endfunction

endpackage

@@ design/slhs_rot_cell.sv @@
// One rotation-mode CORDIC cell of the sin/cos lanes.
// Depends on slhs_pkg.
module slhs_rot_cell import slhs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ROT_IDX_W-1:0] step,
  input  cw_t                  x_in,
  input  cw_t                  y_in,
  input  cw_t                  z_in,
  output cw_t                  x_out,
  output cw_t                  y_out,
  output cw_t                  z_out
);

  cw_t xs, ys, at;

  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  assign at = atan_step(step);

  // rotate towards zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[CW-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + at;
      end
    end
  end

endmodule

@@ design/slhs_vec_cell.sv @@
// One vectoring-mode CORDIC cell of the arc cosine stage.
// Depends on slhs_pkg.
module slhs_vec_cell import slhs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ROT_IDX_W-1:0] step,
  input  cw_t                  x_in,
  input  cw_t                  y_in,
  input  cw_t                  z_in,
  output cw_t                  x_out,
  output cw_t                  y_out,
  output cw_t                  z_out
);

  cw_t xs, ys, at;
  logic y_pos;

  assign xs    = x_in >>> step;
  assign ys    = y_in >>> step;
  assign at    = atan_step(step);
  assign y_pos = !y_in[CW-1] && (y_in != '0);

  // drive y towards zero, accumulate the angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_pos) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + at;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - at;
      end
    end
  end

endmodule

@@ design/slhs_sqrt_cell.sv @@
// One digit cell of the restoring integer square root.
// Depends on slhs_pkg.
module slhs_sqrt_cell import slhs_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [RAD_W-1:0]        rad_in,
  input  logic [REM_W-1:0]        rem_in,
  input  logic [SQRT_STEPS-1:0]   root_in,
  output logic [RAD_W-1:0]        rad_out,
  output logic [REM_W-1:0]        rem_out,
  output logic [SQRT_STEPS-1:0]   root_out
);

  logic [REM_W-1:0] rem_sh, trial;

  assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root_in, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_out  <= rem_sh - trial;
        root_out <= {root_in[SQRT_STEPS-2:0], 1'b1};
      end else begin
        rem_out  <= rem_sh;
        root_out <= {root_in[SQRT_STEPS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/slhs_div_cell.sv @@
// One quotient-bit cell of the restoring divider for the hood position.
// Depends on slhs_pkg.
module slhs_div_cell import slhs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_IDX_W-1:0] step,
  input  logic [Q_W-1:0]       den,
  input  logic [NUM_W-1:0]     num_in,
  input  logic [Q_W-1:0]       quo_in,
  output logic [NUM_W-1:0]     num_out,
  output logic [Q_W-1:0]       quo_out
);

  logic [NUM_W-1:0] trial;

  assign trial = NUM_W'(den) << step;

  always_ff @(posedge clk) begin
    if (en) begin
      if (num_in >= trial) begin
        num_out <= num_in - trial;
        quo_out <= quo_in | (Q_W'(1) << step);
      end else begin
        num_out <= num_in;
        quo_out <= quo_in;
      end
    end
  end

endmodule

@@ design/stray_light_hood_suppression_top.sv @@
// Top level of the stray light hood suppression evaluator.
// Depends on slhs_pkg and the four cell modules.
//
// The block takes one word per clock while not stalled and returns one
// result word for each, in order. Each word passes through a chain of
// cells: three parallel 16-cell CORDIC lanes for the sines and cosines,
// four product and clamp stages, a 31-cell square root, a 16-cell vectoring
// CORDIC for the arc cosine, a 17-cell divider that places the separation
// within the hood, and four Q15 product stages ending in the output register.
// Every stage advances together whenever the output register is empty or is
// being taken, so a full pipeline stalls as a whole while out_ready is low
// and in_ready follows that same advance. Configuration writes are always
// taken (cfg_ready is tied high); write them only while nothing is in
// flight. Indexes beyond the register list are dropped.
module stray_light_hood_suppression_top import slhs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        target_azimuth,
  input  logic signed [15:0] target_elevation,
  input  logic [15:0]        sun_azimuth,
  input  logic signed [15:0] sun_altitude,
  input  logic [15:0]        cloud_cover,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        sun_separation,
  output logic [15:0]        contamination,
  output logic [15:0]        suppression,
  output logic [16:0]        background_penalty,
  output logic [15:0]        signal_transmission,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] hood_inner_angle, hood_outer_angle;
  logic [15:0] suppression_low, suppression_high;
  logic        filter_enabled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hood_inner_angle <= 16'd0;
      hood_outer_angle <= 16'd5461;
      suppression_low  <= 16'd0;
      suppression_high <= 16'd32768;
      filter_enabled   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INNER:     hood_inner_angle <= cfg_data;
        REG_OUTER:     hood_outer_angle <= cfg_data;
        REG_SUPP_LO:   suppression_low  <= cfg_data;
        REG_SUPP_HI:   suppression_high <= cfg_data;
        REG_FILTER_EN: filter_enabled   <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Hood span: outer is held at least one degree above inner.
  logic [Q_W-1:0] inner_q, outer_min, outer_eff, span;
  assign inner_q   = Q_W'(hood_inner_angle);
  assign outer_min = inner_q + ONE_DEG;
  assign outer_eff = (Q_W'(hood_outer_angle) < outer_min) ? outer_min
                                                           : Q_W'(hood_outer_angle);
  assign span      = outer_eff - inner_q;

  // Suppression bounds: order them, then clamp each to one.
  logic [15:0]    sl_min, sl_max;
  logic [Q_W-1:0] supp_lo, supp_hi;
  assign sl_min  = (suppression_low < suppression_high) ? suppression_low
                                                        : suppression_high;
  assign sl_max  = (suppression_low < suppression_high) ? suppression_high
                                                        : suppression_low;
  assign supp_lo = (Q_W'(sl_min) > Q15_ONE) ? Q15_ONE : Q_W'(sl_min);
  assign supp_hi = (Q_W'(sl_max) > Q15_ONE) ? Q15_ONE : Q_W'(sl_max);

  // Global advance: the whole chain moves when the output slot frees.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------
  // Input stage: fold each angle into the CORDIC range
  // ---------------------------------------------------------------------
  logic [31:0] ang [3];
  logic [31:0] ang_f [3];
  logic [2:0]  flip;
  logic [15:0] daz16;

  assign daz16  = target_azimuth - sun_azimuth;
  assign ang[0] = {target_elevation, 16'h0000};
  assign ang[1] = {sun_altitude, 16'h0000};
  assign ang[2] = {daz16, 16'h0000};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [31:0] shifted;
      shifted  = ang[l] + 32'h4000_0000;
      flip[l]  = shifted[31];
      ang_f[l] = flip[l] ? ang[l] + 32'h8000_0000 : ang[l];
    end
  end

  // ---------------------------------------------------------------------
  // Sin/cos lanes: 0 target elevation, 1 sun altitude, 2 azimuth difference
  // ---------------------------------------------------------------------
  cw_t  rx [3][ROT_STEPS+1];
  cw_t  ry [3][ROT_STEPS+1];
  cw_t  rz [3][ROT_STEPS+1];
  logic rv [ROT_STEPS+1];
  sb_t  rsb [ROT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rsb[0].cloud <= cloud_cover;
      rsb[0].flip  <= flip;
      rsb[0].neg   <= 1'b0;
      rsb[0].ac    <= '0;
      rsb[0].sep   <= '0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        rsb[i+1] <= rsb[i];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // load the lane with the gain-compensated unit vector
    always_ff @(posedge clk) begin
      if (en) begin
        rx[l][0] <= CORDIC_GAIN;
        ry[l][0] <= '0;
        rz[l][0] <= {{(CW-32){ang_f[l][31]}}, ang_f[l]};
      end
    end

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
      slhs_rot_cell u_rot (
        .clk   (clk),
        .en    (en),
        .step  (ROT_IDX_W'(i)),
        .x_in  (rx[l][i]),
        .y_in  (ry[l][i]),
        .z_in  (rz[l][i]),
        .x_out (rx[l][i+1]),
        .y_out (ry[l][i+1]),
        .z_out (rz[l][i+1])
      );
    end
  end

  // Undo the fold and trim to 32 bits.
  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (rsb[ROT_STEPS].flip[l]) begin
        sn[l] = 32'(-ry[l][ROT_STEPS]);
        cs[l] = 32'(-rx[l][ROT_STEPS]);
      end else begin
        sn[l] = 32'(ry[l][ROT_STEPS]);
        cs[l] = 32'(rx[l][ROT_STEPS]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Cosine of the separation, clamped, then |c| squared
  // ---------------------------------------------------------------------
  logic signed [63:0] m1_ss, m1_cc, m2_t;
  logic signed [31:0] m1_cd, cc32;
  logic signed [33:0] m2_ss;
  logic signed [34:0] csum;
  logic signed [31:0] cclamp;
  logic [61:0]        m4_sq;
  logic               m1_v, m2_v, m3_v, m4_v;
  sb_t                m1_sb, m2_sb, m3_sb, m4_sb;

  assign cc32 = 32'(m1_cc >>> 30);
  assign csum = 35'(m2_ss) + 35'(m2_t >>> 30);

  always_comb begin
    if (csum > 35'sd1073741824) begin
      cclamp = 32'sd1073741824;
    end else if (csum < -35'sd1073741824) begin
      cclamp = -32'sd1073741824;
    end else begin
      cclamp = 32'(csum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ss <= 64'(sn[0]) * 64'(sn[1]);
      m1_cc <= 64'(cs[0]) * 64'(cs[1]);
      m1_cd <= cs[2];
      m1_sb <= rsb[ROT_STEPS];

      m2_ss <= 34'(m1_ss >>> 30);
      m2_t  <= 64'(cc32) * 64'(m1_cd);
      m2_sb <= m1_sb;

      // carry the word, recording the sign and magnitude of the cosine
      m3_sb <= {m2_sb.cloud, m2_sb.flip, cclamp[31],
                (cclamp[31] ? 31'(-cclamp) : 31'(cclamp)), m2_sb.sep};

      m4_sq <= 62'(m3_sb.ac) * 62'(m3_sb.ac);
      m4_sb <= m3_sb;
    end
  end

  // ---------------------------------------------------------------------
  // Square root of 1 - c^2 (Q60 radicand, Q30 root)
  // ---------------------------------------------------------------------
  logic [RAD_W-1:0]      qrad  [SQRT_STEPS+1];
  logic [REM_W-1:0]      qrem  [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0] qroot [SQRT_STEPS+1];
  logic                  qv    [SQRT_STEPS+1];
  sb_t                   qsb   [SQRT_STEPS+1];
  logic [60:0]           radicand;

  assign radicand = 61'h1000_0000_0000_0000 - m4_sq[60:0];

  always_ff @(posedge clk) begin
    if (en) begin
      qrad[0]  <= {1'b0, radicand};
      qrem[0]  <= '0;
      qroot[0] <= '0;
      qsb[0]   <= m4_sb;
      for (int i = 0; i < SQRT_STEPS; i++) begin
        qsb[i+1] <= qsb[i];
      end
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    slhs_sqrt_cell u_sqrt (
      .clk      (clk),
      .en       (en),
      .rad_in   (qrad[i]),
      .rem_in   (qrem[i]),
      .root_in  (qroot[i]),
      .rad_out  (qrad[i+1]),
      .rem_out  (qrem[i+1]),
      .root_out (qroot[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Arc cosine: vectoring CORDIC on (|c|, root)
  // ---------------------------------------------------------------------
  cw_t  vx [ROT_STEPS+1];
  cw_t  vy [ROT_STEPS+1];
  cw_t  vz [ROT_STEPS+1];
  logic vv [ROT_STEPS+1];
  sb_t  vsb [ROT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0]  <= CW'(qsb[SQRT_STEPS].ac);
      vy[0]  <= CW'(qroot[SQRT_STEPS]);
      vz[0]  <= '0;
      vsb[0] <= qsb[SQRT_STEPS];
      for (int i = 0; i < ROT_STEPS; i++) begin
        vsb[i+1] <= vsb[i];
      end
    end
  end

  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_vec
    slhs_vec_cell u_vec (
      .clk   (clk),
      .en    (en),
      .step  (ROT_IDX_W'(i)),
      .x_in  (vx[i]),
      .y_in  (vy[i]),
      .z_in  (vz[i]),
      .x_out (vx[i+1]),
      .y_out (vy[i+1]),
      .z_out (vz[i+1])
    );
  end

  // Reflect for a negative cosine, round to 16-bit angle, clamp.
  cw_t         zf, zr;
  logic [15:0] sep_now;
  logic        s_v;
  sb_t         s_sb;

  assign zf = vsb[ROT_STEPS].neg ? (34'sd2147483648 - vz[ROT_STEPS]) : vz[ROT_STEPS];
  assign zr = (zf + 34'sd32768) >>> 16;

  always_comb begin
    if (zr[CW-1]) begin
      sep_now = 16'd0;
    end else if (zr > 34'sd32768) begin
      sep_now = 16'h8000;
    end else begin
      sep_now = zr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sb <= {vsb[ROT_STEPS].cloud, vsb[ROT_STEPS].flip, vsb[ROT_STEPS].neg,
               vsb[ROT_STEPS].ac, sep_now};
    end
  end

  // ---------------------------------------------------------------------
  // Position within the hood: round((sep - inner) * 32768 / span)
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] dnum [DIV_STEPS+1];
  logic [Q_W-1:0]   dquo [DIV_STEPS+1];
  logic             dv   [DIV_STEPS+1];
  sb_t              dsb  [DIV_STEPS+1];
  logic [15:0]      sep_off;
  logic [NUM_W-1:0] num_now;

  assign sep_off = s_sb.sep - hood_inner_angle;
  // at or inside the inner angle the numerator is zero, so norm is zero
  assign num_now = (s_sb.sep > hood_inner_angle)
                   ? ({NUM_W'(sep_off)} << 15) + NUM_W'(span[Q_W-1:1])
                   : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      dnum[0] <= num_now;
      dquo[0] <= '0;
      dsb[0]  <= s_sb;
      for (int i = 0; i < DIV_STEPS; i++) begin
        dsb[i+1] <= dsb[i];
      end
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    slhs_div_cell u_div (
      .clk     (clk),
      .en      (en),
      .step    (DIV_IDX_W'(DIV_STEPS - 1 - i)),
      .den     (span),
      .num_in  (dnum[i]),
      .quo_in  (dquo[i]),
      .num_out (dnum[i+1]),
      .quo_out (dquo[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Q15 products: attenuation, contamination, suppression, residual
  // ---------------------------------------------------------------------
  logic [Q_W-1:0] quo_end, norm_now, cloud_c;
  logic [Q_W-1:0] q1_norm, q1_atten;
  logic [Q_W-1:0] q2_contam, q2_supp;
  logic [Q_W-1:0] q3_resid, q3_contam, q3_supp;
  logic [Q_W-1:0] trans_raw, trans_now, bp_now;
  logic           q1_v, q2_v, q3_v;
  sb_t            q1_sb, q2_sb, q3_sb;

  assign quo_end  = dquo[DIV_STEPS];
  // a set top quotient bit means at least twice the span: saturate
  assign norm_now = (quo_end > Q15_ONE) ? Q15_ONE : quo_end;
  assign cloud_c  = (Q_W'(dsb[DIV_STEPS].cloud) > Q15_ONE) ? Q15_ONE
                                                           : Q_W'(dsb[DIV_STEPS].cloud);

  assign trans_raw = Q15_ONE - qmul(TRANS_LOSS, q3_resid);
  assign trans_now = (trans_raw < TRANS_FLOOR) ? TRANS_FLOOR : trans_raw;
  assign bp_now    = Q15_ONE + {q3_resid[Q_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      q1_norm  <= norm_now;
      q1_atten <= Q15_ONE - qmul(CLOUD_ATTEN, cloud_c);
      q1_sb    <= dsb[DIV_STEPS];

      q2_contam <= qmul(Q15_ONE - q1_norm, q1_atten);
      q2_supp   <= filter_enabled ? supp_lo + qmul(supp_hi - supp_lo, q1_norm) : '0;
      q2_sb     <= q1_sb;

      q3_resid  <= qmul(q2_contam, Q15_ONE - q2_supp);
      q3_contam <= q2_contam;
      q3_supp   <= q2_supp;
      q3_sb     <= q2_sb;

      sun_separation      <= q3_sb.sep;
      contamination       <= q3_contam[15:0];
      suppression         <= q3_supp[15:0];
      background_penalty  <= bp_now;
      signal_transmission <= trans_now[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Valid chain: cleared on reset, advanced with the data
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ROT_STEPS; i++) begin
        rv[i] <= 1'b0;
        vv[i] <= 1'b0;
      end
      for (int i = 0; i <= SQRT_STEPS; i++) begin
        qv[i] <= 1'b0;
      end
      for (int i = 0; i <= DIV_STEPS; i++) begin
        dv[i] <= 1'b0;
      end
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      m3_v      <= 1'b0;
      m4_v      <= 1'b0;
      s_v       <= 1'b0;
      q1_v      <= 1'b0;
      q2_v      <= 1'b0;
      q3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      rv[0] <= in_valid;
      for (int i = 0; i < ROT_STEPS; i++) begin
        rv[i+1] <= rv[i];
        vv[i+1] <= vv[i];
      end
      m1_v  <= rv[ROT_STEPS];
      m2_v  <= m1_v;
      m3_v  <= m2_v;
      m4_v  <= m3_v;
      qv[0] <= m4_v;
      for (int i = 0; i < SQRT_STEPS; i++) begin
        qv[i+1] <= qv[i];
      end
      vv[0] <= qv[SQRT_STEPS];
      s_v   <= vv[ROT_STEPS];
      dv[0] <= s_v;
      for (int i = 0; i < DIV_STEPS; i++) begin
        dv[i+1] <= dv[i];
      end
      q1_v      <= dv[DIV_STEPS];
      q2_v      <= q1_v;
      q3_v      <= q2_v;
      out_valid <= q3_v;
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for stray_light_hood_suppression_top: directed table then random
// words, each result checked against a fixed-point predictor of the separation and hood maths.
// Depends on slhs_pkg and the design files; reads nothing else.
`timescale 1ns / 100ps

module tb;
  import slhs_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;   // index beyond the register list
  localparam int DRAIN_CYCLES = 100;         // pipeline is 93 deep
  localparam int HOLD_CYCLES  = 300;

  localparam longint ATAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  typedef struct {
    logic [15:0] sep;
    logic [15:0] contam;
    logic [15:0] supp;
    logic [16:0] penalty;
    logic [15:0] trans;
  } hood_res_t;

  typedef struct {
    logic [15:0] t_az;
    logic [15:0] t_el;
    logic [15:0] s_az;
    logic [15:0] s_alt;
    logic [15:0] cloud;
    bit          typed;   // contamination onwards read off by hand
    logic [15:0] contam;
    logic [15:0] supp;
    logic [16:0] penalty;
    logic [15:0] trans;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        target_azimuth;
  logic signed [15:0] target_elevation;
  logic [15:0]        sun_azimuth;
  logic signed [15:0] sun_altitude;
  logic [15:0]        cloud_cover;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        sun_separation;
  logic [15:0]        contamination;
  logic [15:0]        suppression;
  logic [16:0]        background_penalty;
  logic [15:0]        signal_transmission;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  // Shadow of the hood registers, updated as each write is taken
  logic [15:0] hood_inner, hood_outer, supp_low, supp_high;
  logic        filt_en;

  hood_res_t pending_results[$];
  int        fail_count = 0;
  bit        no_idle = 0;
  bit        squeeze = 0;

  stray_light_hood_suppression_top u_top (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint qmul15(longint a, longint b);
    return (a * b + 16384) >>> 15;
  endfunction

  // Rotation CORDIC in Q30; fold the left half-plane onto the right first
  function automatic void sin_cos_q30(input logic [31:0] ang, output longint sn,
                                      output longint cs);
    logic [31:0] probe;
    int          sang;
    bit          flip;
    longint      x, y, z, nx;
    probe = ang + 32'h4000_0000;
    flip  = probe[31];
    if (flip) ang = ang + 32'h8000_0000;
    sang = ang;
    z = sang;
    x = 652032875;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TURN[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Arc cosine of a Q30 cosine, in 16 bit binary angle units
  function automatic longint arc_cos_bam(longint c);
    longint ac, x, y, z, nx, r;
    ac = (c < 0) ? -c : c;
    x  = ac;
    z  = 0;
    y  = root_floor((64'd1 << 60) - ac * ac);
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TURN[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TURN[i];
      end
      x = nx;
    end
    if (c < 0) z = 64'sd2147483648 - z;
    r = (z + 32768) >>> 16;
    if (r < 0) r = 0;
    if (r > 32768) r = 32768;
    return r;
  endfunction

  function automatic hood_res_t hood_response(logic [15:0] t_az, logic [15:0] t_el,
                                              logic [15:0] s_az, logic [15:0] s_alt,
                                              logic [15:0] cloud_in);
    hood_res_t res;
    logic [15:0] daz16;
    longint s0, c0, s1, c1, sd, cd, cosang, sep, cloud;
    longint inner, outer, span, norm, lo, hi, atten, contam, supp, resid, trans;
    daz16 = t_az - s_az;
    sin_cos_q30({t_el, 16'h0}, s0, c0);
    sin_cos_q30({s_alt, 16'h0}, s1, c1);
    sin_cos_q30({daz16, 16'h0}, sd, cd);
    cosang = ((s0 * s1) >>> 30) + ((((c0 * c1) >>> 30) * cd) >>> 30);
    if (cosang > 64'sd1073741824) cosang = 64'sd1073741824;
    if (cosang < -64'sd1073741824) cosang = -64'sd1073741824;
    sep = arc_cos_bam(cosang);

    cloud = (cloud_in > 16'd32768) ? 32768 : cloud_in;
    inner = hood_inner;
    outer = hood_outer;
    if (outer < inner + 182) outer = inner + 182;
    span = outer - inner;
    if (sep <= inner) norm = 0;
    else begin
      norm = (((sep - inner) << 15) + span / 2) / span;
      if (norm > 32768) norm = 32768;
    end

    lo = (supp_low < supp_high) ? supp_low : supp_high;
    hi = (supp_low < supp_high) ? supp_high : supp_low;
    if (lo > 32768) lo = 32768;
    if (hi > 32768) hi = 32768;

    atten  = 32768 - qmul15(22938, cloud);
    contam = qmul15(32768 - norm, atten);
    supp   = filt_en ? lo + qmul15(hi - lo, norm) : 0;
    resid  = qmul15(contam, 32768 - supp);
    trans  = 32768 - qmul15(4915, resid);
    if (trans < 22938) trans = 22938;

    res.sep     = sep[15:0];
    res.contam  = contam[15:0];
    res.supp    = supp[15:0];
    res.penalty = 17'(32768 + 2 * resid);
    res.trans   = trans[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void check_field(string name, longint got, longint want);
    if (got != want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    hood_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, sep %0d", $realtime, sun_separation);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("sun_separation", sun_separation, want.sep);
        check_field("contamination", contamination, want.contam);
        check_field("suppression", suppression, want.supp);
        check_field("background_penalty", background_penalty, want.penalty);
        check_field("signal_transmission", signal_transmission, want.trans);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Offer one word after a random gap; hold it until taken, then log its result.
  task automatic send_word(row_t w);
    int        gap;
    hood_res_t want;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    target_azimuth   <= w.t_az;
    target_elevation <= w.t_el;
    sun_azimuth      <= w.s_az;
    sun_altitude     <= w.s_alt;
    cloud_cover      <= w.cloud;
    do @(posedge clk); while (!in_ready);
    want = hood_response(w.t_az, w.t_el, w.s_az, w.s_alt, w.cloud);
    if (w.typed) begin
      want.contam  = w.contam;
      want.supp    = w.supp;
      want.penalty = w.penalty;
      want.trans   = w.trans;
    end
    pending_results.push_back(want);
  endtask

  // Drain the pipeline, then write all five registers and one spare index
  task automatic set_hood(logic [15:0] inner, logic [15:0] outer, logic [15:0] lo,
                          logic [15:0] hi, logic en);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{REG_INNER, REG_OUTER, REG_SUPP_LO, REG_SUPP_HI, REG_FILTER_EN, REG_SPARE};
    val = '{inner, outer, lo, hi, {15'd0, en}, 16'($urandom)};
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_INNER:     hood_inner = val[i];
        REG_OUTER:     hood_outer = val[i];
        REG_SUPP_LO:   supp_low   = val[i];
        REG_SUPP_HI:   supp_high  = val[i];
        REG_FILTER_EN: filt_en    = val[i][0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t random_word();
    row_t w;
    w.typed = 0;
    w.t_az  = $urandom;
    w.t_el  = ($urandom_range(0, 9) < 8) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                         : 16'($urandom);
    // Put the sun near the target often, so the separation falls inside the hood
    if ($urandom_range(0, 9) < 4) begin
      w.s_az  = w.t_az + 16'($signed($urandom_range(0, 8000)) - 4000);
      w.s_alt = w.t_el + 16'($signed($urandom_range(0, 8000)) - 4000);
    end else begin
      w.s_az  = $urandom;
      w.s_alt = ($urandom_range(0, 9) < 8) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                           : 16'($urandom);
    end
    w.cloud = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 32768)) : 16'($urandom);
    return w;
  endfunction

  // ---------------------------------------------------------------- receiver
  // Stall at random; once, while squeeze is set, hold off long enough to fill the pipe.
  initial begin
    int gap;
    bit held = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze && !held) begin
        gap  = HOLD_CYCLES;
        held = 1;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    row_t rows[$];
    row_t w;
    bit   hood_closed = 0;
    logic [15:0] cfgs [7][5];

    rst              = 1'b1;
    in_valid         = 1'b0;
    target_azimuth   = '0;
    target_elevation = '0;
    sun_azimuth      = '0;
    sun_altitude     = '0;
    cloud_cover      = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_INNER;
    cfg_data         = '0;
    hood_inner = 16'd0;  hood_outer = 16'd5461;
    supp_low   = 16'd0;  supp_high  = 16'd32768;
    filt_en    = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: predictor rows under reset settings, then hand-read rows with the
    // hood wide open past 180 degrees and the filter off, so norm is always zero.
    rows = '{
      '{16'd0,     16'd0,      16'd0,     16'd0,      16'd0,     0, 0, 0, 0, 0},
      '{16'd100,   16'd200,    16'd0,     16'd0,      16'd32768, 0, 0, 0, 0, 0},
      '{16'd0,     16'd16384,  16'd32768, 16'd16384,  16'd0,     0, 0, 0, 0, 0},
      '{16'd0,     16'hC000,   16'd0,     16'd16384,  16'd16384, 0, 0, 0, 0, 0},
      '{16'd0,     16'd0,      16'd32768, 16'd0,      16'd0,     0, 0, 0, 0, 0},
      '{16'hFFFF,  16'd0,      16'd0,     16'd0,      16'hFFFF,  0, 0, 0, 0, 0},
      '{16'd0,     16'h7FFF,   16'd0,     16'h8000,   16'd1,     0, 0, 0, 0, 0},
      '{16'd1000,  16'h8000,   16'hFFFF,  16'h7FFF,   16'd32767, 0, 0, 0, 0, 0},
      '{16'd0,     16'd0,      16'd2730,  16'd0,      16'd0,     0, 0, 0, 0, 0},
      '{16'd0,     16'd0,      16'd5461,  16'd0,      16'd0,     0, 0, 0, 0, 0},
      '{16'd0,     16'd0,      16'd6000,  16'd0,      16'd20000, 0, 0, 0, 0, 0},
      '{16'h5555,  16'h2AAA,   16'hAAAA,  16'hD555,   16'h5555,  0, 0, 0, 0, 0},
      '{16'd0,     16'd0,      16'd0,     16'd0,      16'd0,
        1, 16'd32768, 16'd0, 17'd98304, 16'd27853},
      '{16'd9000,  16'd3000,   16'd9000,  16'd3000,   16'd32768,
        1, 16'd9830,  16'd0, 17'd52428, 16'd31294},
      '{16'd0,     16'd16384,  16'd32768, 16'hC000,   16'hFFFF,
        1, 16'd9830,  16'd0, 17'd52428, 16'd31294},
      '{16'd40000, 16'd0,      16'd7232,  16'd0,      16'd0,
        1, 16'd32768, 16'd0, 17'd98304, 16'd27853}
    };
    foreach (rows[i]) begin
      if (rows[i].typed && !hood_closed) begin
        set_hood(16'd32768, 16'd65535, 16'd0, 16'd32768, 1'b0);
        hood_closed = 1;
      end
      send_word(rows[i]);
    end

    // Random phases, each under its own settings; extremes first, then random ones
    cfgs = '{
      '{16'd0,     16'd5461,  16'd0,     16'd32768, 16'd1},
      '{16'd0,     16'd0,     16'd0,     16'd32768, 16'd1},
      '{16'd32768, 16'd65535, 16'd65535, 16'd65535, 16'd1},
      '{16'd4000,  16'd2000,  16'd30000, 16'd1000,  16'd1},
      '{16'd100,   16'd1000,  16'd5000,  16'd20000, 16'd0},
      '{16'd65535, 16'd0,     16'd65535, 16'd0,     16'd1},
      '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0}
    };
    for (int p = 0; p < 9; p++) begin
      if (p < 7) set_hood(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4][0]);
      else set_hood(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 12000)),
                    16'($urandom), 16'($urandom), 1'($urandom));
      no_idle = (p == 1);
      squeeze = (p == 1);
      for (int n = 0; n < 105; n++) begin
        w = random_word();
        send_word(w);
      end
    end

    // Drop valid, wait for the last results, then let the pipe settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** stray_light_hood_suppression_top: PASSED **");
    else
      $display("** stray_light_hood_suppression_top: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** stray_light_hood_suppression_top: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
design/slhs_pkg.sv
design/slhs_rot_cell.sv
design/slhs_vec_cell.sv
design/slhs_sqrt_cell.sv
design/slhs_div_cell.sv
design/stray_light_hood_suppression_top.sv
dv/tb.sv
